### hw/rtl/necir_pkg.sv
// Shared types, widths, codes and reset values of the NEC infrared frame decoder.
package necir_pkg;

	localparam int TICK_W         = 15;
	localparam int FIELD_W        = 16;
	localparam int POS_W          = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int FIELD_BITS_DEF = 16;

	typedef logic [TICK_W-1:0]    tick_t;
	typedef logic [FIELD_W-1:0]   field_t;
	typedef logic [1:0]           kind_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [POS_W-1:0]     pos_t;

	localparam kind_t KIND_DECODED  = 2'd0;
	localparam kind_t KIND_REPEAT   = 2'd1;
	localparam kind_t KIND_REJECTED = 2'd2;
	localparam kind_t KIND_UNKNOWN  = 2'd3;

	localparam cfg_idx_t REG_LEADER_MARK  = 3'd0;
	localparam cfg_idx_t REG_LEADER_SPACE = 3'd1;
	localparam cfg_idx_t REG_BIT_MARK     = 3'd2;
	localparam cfg_idx_t REG_ZERO_SPACE   = 3'd3;
	localparam cfg_idx_t REG_ONE_SPACE    = 3'd4;
	localparam cfg_idx_t REG_REPEAT_MARK  = 3'd5;
	localparam cfg_idx_t REG_REPEAT_SPACE = 3'd6;
	localparam cfg_idx_t REG_TOLERANCE    = 3'd7;

	localparam tick_t RST_LEADER_MARK  = 15'd9000;
	localparam tick_t RST_LEADER_SPACE = 15'd4500;
	localparam tick_t RST_BIT_MARK     = 15'd560;
	localparam tick_t RST_ZERO_SPACE   = 15'd560;
	localparam tick_t RST_ONE_SPACE    = 15'd1690;
	localparam tick_t RST_REPEAT_MARK  = 15'd9000;
	localparam tick_t RST_REPEAT_SPACE = 15'd2250;
	localparam tick_t RST_TOLERANCE    = 15'd200;

	localparam pos_t POS_MAX    = '1;
	localparam pos_t REPEAT_LEN = 6'd2;

endpackage

### hw/rtl/necir_ifs.sv
// Handshake channel interfaces: captured symbols, decoded results and register writes.
interface necir_sym_if;
	import necir_pkg::*;
	logic  valid;
	logic  ready;
	tick_t mark_ticks;
	tick_t space_ticks;
	logic  frame_end;
	modport source (output valid, mark_ticks, space_ticks, frame_end, input ready);
	modport sink (input valid, mark_ticks, space_ticks, frame_end, output ready);
endinterface

interface necir_res_if;
	import necir_pkg::*;
	logic   valid;
	logic   ready;
	kind_t  frame_kind;
	field_t address_out;
	field_t command_out;
	modport source (output valid, frame_kind, address_out, command_out, input ready);
	modport sink (input valid, frame_kind, address_out, command_out, output ready);
endinterface

interface necir_cfg_if;
	import necir_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	tick_t    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/nec_ir_frame_decoder_top.sv
// NEC infrared frame decoder: one captured symbol per cycle in unless the result stalls, one result per frame out.
// The decoder takes one captured symbol (mark ticks, space ticks, end-of-frame flag) in every
// clock cycle. A symbol passes through an input register, is checked against the timing
// windows in the following cycle and, on the last symbol of a frame, its result lands in the
// output register as soon as the previous result has been taken or none is pending.
// The throughput is set by the single window-check stage, which updates the frame state once
// per cycle; only a stalled result output holds symbols back. Timing registers may be written
// at any time through the configuration channel, which is always ready, but should only be
// changed while no frame is in flight.
module nec_ir_frame_decoder_top #(
	parameter int FIELD_BITS = necir_pkg::FIELD_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	necir_sym_if.sink    sym,
	necir_res_if.source  res,
	necir_cfg_if.sink    cfg
);
	import necir_pkg::*;

	localparam int   DATA_BITS = 2 * FIELD_BITS;
	localparam pos_t FRAME_LEN = POS_W'(2 + DATA_BITS);
	localparam pos_t LAST_BIT  = POS_W'(DATA_BITS);

	function automatic logic in_win(input tick_t v, input tick_t spec, input tick_t tol);
		tick_t           lo;
		logic [TICK_W:0] hi;
		lo = (spec > tol) ? tick_t'(spec - tol) : '0;
		hi = {1'b0, spec} + {1'b0, tol};
		return (v > lo) && ({1'b0, v} < hi);
	endfunction

	// Timing registers
	tick_t leader_mark_q, leader_space_q, bit_mark_q, zero_space_q;
	tick_t one_space_q, repeat_mark_q, repeat_space_q, tolerance_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_mark_q  <= RST_LEADER_MARK;
			leader_space_q <= RST_LEADER_SPACE;
			bit_mark_q     <= RST_BIT_MARK;
			zero_space_q   <= RST_ZERO_SPACE;
			one_space_q    <= RST_ONE_SPACE;
			repeat_mark_q  <= RST_REPEAT_MARK;
			repeat_space_q <= RST_REPEAT_SPACE;
			tolerance_q    <= RST_TOLERANCE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEADER_MARK:  leader_mark_q  <= cfg.data;
				REG_LEADER_SPACE: leader_space_q <= cfg.data;
				REG_BIT_MARK:     bit_mark_q     <= cfg.data;
				REG_ZERO_SPACE:   zero_space_q   <= cfg.data;
				REG_ONE_SPACE:    one_space_q    <= cfg.data;
				REG_REPEAT_MARK:  repeat_mark_q  <= cfg.data;
				REG_REPEAT_SPACE: repeat_space_q <= cfg.data;
				REG_TOLERANCE:    tolerance_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register stage
	logic  valid_s1;
	tick_t mark_s1, space_s1;
	logic  last_s1;
	logic  res_valid_q;
	logic  advance;
	logic  consume;

	assign advance   = !res_valid_q || res.ready;
	assign consume   = valid_s1 && advance;
	assign sym.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym.ready) begin
			valid_s1 <= sym.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym.valid && sym.ready) begin
			mark_s1  <= sym.mark_ticks;
			space_s1 <= sym.space_ticks;
			last_s1  <= sym.frame_end;
		end
	end

	// Frame state
	pos_t                   pos_q;
	logic                   good_q;
	logic                   rep_q;
	logic [DATA_BITS-1:0]   shift_q;
	logic [FIELD_BITS-1:0]  held_addr_q, held_cmd_q;

	logic                   leader_hit, repeat_hit, one_hit, zero_hit;
	pos_t                   pos_inc, pos_n;
	logic                   good_n, rep_n;
	logic [DATA_BITS-1:0]   shift_n;
	logic                   store_frame;
	kind_t                  kind_n;
	field_t                 addr_n, cmd_n;

	always_comb begin
		leader_hit = in_win(mark_s1, leader_mark_q, tolerance_q)
			&& in_win(space_s1, leader_space_q, tolerance_q);
		repeat_hit = in_win(mark_s1, repeat_mark_q, tolerance_q)
			&& in_win(space_s1, repeat_space_q, tolerance_q);
		one_hit    = in_win(mark_s1, bit_mark_q, tolerance_q)
			&& in_win(space_s1, one_space_q, tolerance_q);
		zero_hit   = in_win(mark_s1, bit_mark_q, tolerance_q)
			&& in_win(space_s1, zero_space_q, tolerance_q);

		good_n  = good_q;
		rep_n   = rep_q;
		shift_n = shift_q;
		if (pos_q == '0) begin
			good_n = leader_hit;
			rep_n  = repeat_hit;
		end else if (pos_q <= LAST_BIT) begin
			if (one_hit) begin
				for (int i = 0; i < DATA_BITS; i++) begin
					if (POS_W'(i + 1) == pos_q) begin
						shift_n[i] = 1'b1;
					end
				end
			end else if (!zero_hit) begin
				good_n = 1'b0;
			end
		end

		// The counter saturates so that an overlong frame never wraps to a valid length.
		pos_inc = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
		pos_n   = pos_inc;

		store_frame = 1'b0;
		kind_n      = KIND_UNKNOWN;
		addr_n      = '0;
		cmd_n       = '0;
		if (pos_inc == FRAME_LEN) begin
			if (good_n) begin
				store_frame = 1'b1;
				kind_n      = KIND_DECODED;
				addr_n[FIELD_BITS-1:0] = shift_n[FIELD_BITS-1:0];
				cmd_n[FIELD_BITS-1:0]  = shift_n[DATA_BITS-1:FIELD_BITS];
			end else begin
				kind_n = KIND_REJECTED;
			end
		end else if (pos_inc == REPEAT_LEN) begin
			if (rep_n) begin
				kind_n = KIND_REPEAT;
				addr_n[FIELD_BITS-1:0] = held_addr_q;
				cmd_n[FIELD_BITS-1:0]  = held_cmd_q;
			end else begin
				kind_n = KIND_REJECTED;
			end
		end

		if (last_s1) begin
			pos_n   = '0;
			good_n  = 1'b1;
			rep_n   = 1'b0;
			shift_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			good_q      <= 1'b1;
			rep_q       <= 1'b0;
			shift_q     <= '0;
			held_addr_q <= '0;
			held_cmd_q  <= '0;
		end else if (consume) begin
			pos_q   <= pos_n;
			good_q  <= good_n;
			rep_q   <= rep_n;
			shift_q <= shift_n;
			if (last_s1 && store_frame) begin
				held_addr_q <= addr_n[FIELD_BITS-1:0];
				held_cmd_q  <= cmd_n[FIELD_BITS-1:0];
			end
		end
	end

	// Result register
	kind_t  kind_q;
	field_t addr_q, cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			kind_q <= kind_n;
			addr_q <= addr_n;
			cmd_q  <= cmd_n;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.frame_kind  = kind_q;
	assign res.address_out = addr_q;
	assign res.command_out = cmd_q;

endmodule

### sim/nec_ir_frame_decoder_top_tb.sv
// NEC infrared frame decoder testbench: directed and random frames checked against a bench decoder.
`timescale 1ns / 100ps

module nec_ir_frame_decoder_top_tb;
	import necir_pkg::*;

	localparam int FIELD_BITS  = FIELD_BITS_DEF;
	localparam int DATA_SYMS   = 2 * FIELD_BITS;
	localparam int FRAME_SYMS  = 2 + DATA_SYMS;
	localparam int TICK_MAX    = (1 << TICK_W) - 1;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 280;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		tick_t mark;
		tick_t space;
		logic  last;
	} ir_symbol_t;

	typedef struct packed {
		kind_t  kind;
		field_t addr;
		field_t cmd;
	} ir_result_t;

	logic clk = 1'b0;
	logic arst_n;

	necir_sym_if sym_ch ();
	necir_res_if res_ch ();
	necir_cfg_if cfg_ch ();

	nec_ir_frame_decoder_top #(.FIELD_BITS(FIELD_BITS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ir_symbol_t  symbol_backlog [$];
	ir_result_t  frames_due [$];
	tick_t       timing_reg [8];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          mismatch_count;
	int          cycle_count;
	bit          long_hold_req;
	bit          hold_done;
	int          hold_left;

	// Frame state of the bench decoder.
	int unsigned              sym_pos;
	bit                       frame_ok;
	bit                       repeat_ok;
	logic [DATA_SYMS-1:0]     bit_acc;
	field_t                   held_addr;
	field_t                   held_cmd;

	task automatic flag_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Strictly inside spec +/- tolerance; the lower bound stops at zero.
	function automatic bit in_band(tick_t v, tick_t spec);
		int tol, lo, hi;
		tol = int'(timing_reg[REG_TOLERANCE]);
		lo  = (int'(spec) > tol) ? int'(spec) - tol : 0;
		hi  = int'(spec) + tol;
		return (int'(v) > lo) && (int'(v) < hi);
	endfunction

	function automatic bit pair_ok(tick_t m, tick_t s, tick_t sm, tick_t ss);
		return in_band(m, sm) && in_band(s, ss);
	endfunction

	function automatic void clear_frame();
		sym_pos   = 0;
		frame_ok  = 1'b1;
		repeat_ok = 1'b0;
		bit_acc   = '0;
	endfunction

	function automatic void take_symbol(tick_t m, tick_t s, logic last);
		ir_result_t r;
		if (sym_pos == 0) begin
			frame_ok  = pair_ok(m, s, timing_reg[REG_LEADER_MARK], timing_reg[REG_LEADER_SPACE]);
			repeat_ok = pair_ok(m, s, timing_reg[REG_REPEAT_MARK], timing_reg[REG_REPEAT_SPACE]);
		end else if (sym_pos <= DATA_SYMS) begin
			if (pair_ok(m, s, timing_reg[REG_BIT_MARK], timing_reg[REG_ONE_SPACE]))
				bit_acc[sym_pos-1] = 1'b1;
			else if (!pair_ok(m, s, timing_reg[REG_BIT_MARK], timing_reg[REG_ZERO_SPACE]))
				frame_ok = 1'b0;
		end
		if (sym_pos < POS_MAX)
			sym_pos++;
		if (!last)
			return;
		r = '{KIND_UNKNOWN, '0, '0};
		if (sym_pos == FRAME_SYMS) begin
			if (frame_ok) begin
				held_addr = bit_acc[FIELD_BITS-1:0];
				held_cmd  = bit_acc[DATA_SYMS-1:FIELD_BITS];
				r = '{KIND_DECODED, held_addr, held_cmd};
			end else begin
				r.kind = KIND_REJECTED;
			end
		end else if (sym_pos == REPEAT_LEN) begin
			if (repeat_ok)
				r = '{KIND_REPEAT, held_addr, held_cmd};
			else
				r.kind = KIND_REJECTED;
		end
		frames_due.push_back(r);
		clear_frame();
	endfunction

	// Mostly a duration inside the window; the flawed share lands on an edge, an extreme or anywhere.
	function automatic tick_t pick_ticks(tick_t spec, int flaw_pct);
		int tol, lo, hi, v;
		tol = int'(timing_reg[REG_TOLERANCE]);
		lo  = (int'(spec) > tol) ? int'(spec) - tol : 0;
		hi  = int'(spec) + tol;
		if ($urandom_range(99) >= flaw_pct && hi - lo >= 2 && lo < TICK_MAX) begin
			v = $urandom_range(lo + 1, (hi - 1 > TICK_MAX) ? TICK_MAX : hi - 1);
		end else begin
			case ($urandom_range(5))
				0: v = lo;
				1: v = hi;
				2: v = 0;
				3: v = TICK_MAX;
				default: v = $urandom_range(TICK_MAX);
			endcase
		end
		if (v > TICK_MAX)
			v = TICK_MAX;
		return tick_t'(v);
	endfunction

	function automatic void push_symbol(int m, int s, bit last);
		ir_symbol_t item;
		item.mark  = tick_t'(m);
		item.space = tick_t'(s);
		item.last  = last;
		symbol_backlog.push_back(item);
	endfunction

	// A frame shaped like a real one: leader or repeat code first, then data bits, then free symbols.
	function automatic void add_frame(int len, bit as_repeat, int flaw_pct);
		tick_t sm, ss;
		for (int i = 0; i < len; i++) begin
			if (i == 0) begin
				sm = as_repeat ? timing_reg[REG_REPEAT_MARK] : timing_reg[REG_LEADER_MARK];
				ss = as_repeat ? timing_reg[REG_REPEAT_SPACE] : timing_reg[REG_LEADER_SPACE];
			end else begin
				sm = timing_reg[REG_BIT_MARK];
				ss = $urandom_range(1) ? timing_reg[REG_ONE_SPACE] : timing_reg[REG_ZERO_SPACE];
			end
			if (i > DATA_SYMS || (as_repeat && i > 0))
				push_symbol(int'(pick_ticks(sm, 100)), int'(pick_ticks(ss, 100)),
					i == len - 1);
			else
				push_symbol(int'(pick_ticks(sm, flaw_pct)), int'(pick_ticks(ss, flaw_pct)),
					i == len - 1);
		end
	endfunction

	function automatic int add_random_frames(int budget);
		int n, r, len, flaw;
		n = 0;
		while (n < budget) begin
			r    = $urandom_range(99);
			flaw = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 4);
			if (r < 40)
				len = FRAME_SYMS;
			else if (r < 70)
				len = REPEAT_LEN;
			else if (r < 82)
				len = $urandom_range(1, 4);
			else if (r < 95)
				len = $urandom_range(FRAME_SYMS - 3, FRAME_SYMS + 2);
			else
				len = $urandom_range(POS_MAX + 1, POS_MAX + 7);
			if (r >= 70 && r < 82)
				flaw = 100;
			add_frame(len, r >= 40 && r < 70, flaw);
			n += len;
		end
		return n;
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (symbol_backlog.size() != 0 || sym_ch.valid || frames_due.size() != 0);
		// Every frame ends in a result, so this wait only lets the pipeline settle.
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_timing(input tick_t vals [8]);
		@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= cfg_idx_t'(i);
			cfg_ch.data  <= vals[i];
			do @(posedge clk);
			while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(int budget);
		void'(add_random_frames(budget));
		wait_idle();
	endtask

	// Symbol driver; the bench decoder is advanced on every accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		ir_symbol_t nxt;
		if (!arst_n) begin
			sym_ch.valid       <= 1'b0;
			sym_ch.mark_ticks  <= '0;
			sym_ch.space_ticks <= '0;
			sym_ch.frame_end   <= 1'b0;
			clear_frame();
			held_addr = '0;
			held_cmd  = '0;
		end else begin
			if (sym_ch.valid && sym_ch.ready)
				take_symbol(sym_ch.mark_ticks, sym_ch.space_ticks, sym_ch.frame_end);
			if (!sym_ch.valid || sym_ch.ready) begin
				if (symbol_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = symbol_backlog.pop_front();
					sym_ch.valid       <= 1'b1;
					sym_ch.mark_ticks  <= nxt.mark;
					sym_ch.space_ticks <= nxt.space;
					sym_ch.frame_end   <= nxt.last;
				end else begin
					sym_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		ir_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (frames_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d addr %h cmd %h",
						res_ch.frame_kind, res_ch.address_out, res_ch.command_out));
				end else begin
					want = frames_due.pop_front();
					if (res_ch.frame_kind !== want.kind)
						flag_mismatch($sformatf("frame_kind %0d, expected %0d",
							res_ch.frame_kind, want.kind));
					if (res_ch.address_out !== want.addr)
						flag_mismatch($sformatf("address_out %h, expected %h",
							res_ch.address_out, want.addr));
					if (res_ch.command_out !== want.cmd)
						flag_mismatch($sformatf("command_out %h, expected %h",
							res_ch.command_out, want.cmd));
				end
			end
			if (long_hold_req && !hold_done)
				res_ch.ready <= 1'b0;
			else
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_reg[REG_LEADER_MARK]  <= RST_LEADER_MARK;
			timing_reg[REG_LEADER_SPACE] <= RST_LEADER_SPACE;
			timing_reg[REG_BIT_MARK]     <= RST_BIT_MARK;
			timing_reg[REG_ZERO_SPACE]   <= RST_ZERO_SPACE;
			timing_reg[REG_ONE_SPACE]    <= RST_ONE_SPACE;
			timing_reg[REG_REPEAT_MARK]  <= RST_REPEAT_MARK;
			timing_reg[REG_REPEAT_SPACE] <= RST_REPEAT_SPACE;
			timing_reg[REG_TOLERANCE]    <= RST_TOLERANCE;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			timing_reg[cfg_ch.index] <= cfg_ch.data;
		end
	end

	// Long receiver hold-off, counted here so that the sender keeps offering symbols meanwhile.
	always @(posedge clk) begin
		if (long_hold_req && !hold_done) begin
			if (hold_left < HOLD_CYCLES)
				hold_left <= hold_left + 1;
			else
				hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		tick_t tvals [8];
		arst_n             = 1'b0;
		sym_ch.valid       = 1'b0;
		sym_ch.mark_ticks  = '0;
		sym_ch.space_ticks = '0;
		sym_ch.frame_end   = 1'b0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = REG_LEADER_MARK;
		cfg_ch.data        = '0;
		mismatch_count     = 0;
		cycle_count        = 0;
		long_hold_req      = 1'b0;
		hold_done          = 1'b0;
		hold_left          = 0;
		send_idle_pct      = 27;
		recv_idle_pct      = 47;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed symbols under the reset timing.
		push_symbol(9000, 2250, 1'b0);          // repeat code before any decoded frame
		push_symbol(560, 560, 1'b1);
		push_symbol(0, 0, 1'b1);                // one-symbol frame
		push_symbol(TICK_MAX, 0, 1'b1);
		push_symbol(TICK_MAX, TICK_MAX, 1'b0);  // two symbols without repeat timing
		push_symbol(0, 0, 1'b1);
		push_symbol(8800, 2250, 1'b0);          // mark sitting on the lower window edge
		push_symbol(560, 560, 1'b1);
		push_symbol(8801, 2449, 1'b0);          // just inside both edges
		push_symbol(0, TICK_MAX, 1'b1);
		push_symbol(9000, 2450, 1'b0);          // space sitting on the upper window edge
		push_symbol(560, 560, 1'b1);
		push_symbol(9000, 4500, 1'b0);          // three-symbol frame
		push_symbol(560, 1690, 1'b0);
		push_symbol(560, 560, 1'b1);
		wait_idle();

		run_phase(PHASE_ITEMS);

		tvals[REG_LEADER_MARK]  = tick_t'($urandom_range(50, 5000));
		tvals[REG_LEADER_SPACE] = tick_t'($urandom_range(50, 5000));
		tvals[REG_BIT_MARK]     = tick_t'($urandom_range(50, 5000));
		tvals[REG_ZERO_SPACE]   = tick_t'($urandom_range(50, 5000));
		tvals[REG_ONE_SPACE]    = tick_t'($urandom_range(50, 5000));
		tvals[REG_REPEAT_MARK]  = tick_t'($urandom_range(50, 5000));
		tvals[REG_REPEAT_SPACE] = tick_t'($urandom_range(50, 5000));
		tvals[REG_TOLERANCE]    = tick_t'($urandom_range(20, 300));
		program_timing(tvals);
		run_phase(PHASE_ITEMS);

		// Widest windows: every nonzero duration matches every timing.
		send_idle_pct = 47;
		recv_idle_pct = 27;
		foreach (tvals[i])
			tvals[i] = tick_t'(TICK_MAX);
		program_timing(tvals);
		for (int i = 0; i < 30; i++)
			add_frame(REPEAT_LEN, 1'b1, 0);
		long_hold_req = 1'b1;
		run_phase(PHASE_ITEMS);

		// Zero tolerance: no window can match.
		foreach (tvals[i])
			tvals[i] = '0;
		program_timing(tvals);
		run_phase(PHASE_ITEMS);

		// Tolerance of one leaves the spec value itself as the only match.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (tvals[i])
			tvals[i] = tick_t'($urandom_range(1, TICK_MAX));
		tvals[REG_TOLERANCE] = tick_t'(1);
		program_timing(tvals);
		run_phase(PHASE_ITEMS);

		foreach (tvals[i])
			tvals[i] = '0;
		tvals[REG_TOLERANCE] = tick_t'(TICK_MAX);
		program_timing(tvals);
		run_phase(PHASE_ITEMS);

		if (frames_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", frames_due.size()));
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
